// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define L16P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define L16P_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ----- hdl/l16p_pkg.sv -----
// ----------------------------------------------------------------------------
// l16p_pkg
// Constants, command types and lookup tables of the lidar packet decoder.
// ----------------------------------------------------------------------------
package l16p_pkg;

  localparam int unsigned LASERS       = 16;
  localparam int unsigned BLOCKS       = 12;
  localparam int unsigned SEQUENCES    = 2;
  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned RECORD_BYTES = 3;
  localparam int unsigned BLOCK_BYTES  = HEADER_BYTES + LASERS * SEQUENCES * RECORD_BYTES;

  localparam int unsigned OFF_W  = $clog2(BLOCK_BYTES);
  localparam int unsigned BLK_W  = $clog2(BLOCKS + 1);
  localparam int unsigned LCNT_W = (LASERS > 1) ? $clog2(LASERS) : 1;
  localparam int unsigned SEQ_W  = $clog2(SEQUENCES + 1);

  localparam int unsigned OFF_AZ_LO = 2;
  localparam int unsigned OFF_AZ_HI = 3;

  // Byte position inside one range/intensity record.
  localparam logic [1:0] SUB_LO  = 2'd0;
  localparam logic [1:0] SUB_HI  = 2'd1;
  localparam logic [1:0] SUB_INT = 2'd2;

  localparam logic [31:0] CHANNEL_NS  = 32'd2304;
  localparam logic [31:0] RECHARGE_NS = 32'd18430;
  localparam logic [31:0] SEQUENCE_NS = CHANNEL_NS * LASERS + RECHARGE_NS;
  localparam logic [31:0] BLOCK_NS    = SEQUENCE_NS * SEQUENCES;

  localparam logic [16:0] AZ_FULL    = 17'd36000;
  localparam logic [16:0] AZ_QUARTER = 17'd9000;
  localparam logic [16:0] AZ_HALF    = 17'd18000;
  localparam logic [16:0] AZ_3QUART  = 17'd27000;

  // Centidegrees to Q30 radians.
  localparam logic [33:0] SIN_K   = 34'd187403;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Reciprocals, rounded up, for exact division of 32-bit values.
  localparam logic [63:0] M72 = ((64'd1 << 39) + 64'd71) / 64'd72;
  localparam logic [63:0] M42 = ((64'd1 << 38) + 64'd41) / 64'd42;
  localparam logic [63:0] M20 = ((64'd1 << 37) + 64'd19) / 64'd20;
  localparam logic [63:0] M6  = ((64'd1 << 35) + 64'd5) / 64'd6;
  // Reciprocal of 5 for values below 2^19.
  localparam logic [63:0] M5  = ((64'd1 << 22) + 64'd4) / 64'd5;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE = 5'd0;
  localparam op_t OP_ANG  = 5'd1;
  localparam op_t OP_T    = 5'd2;
  localparam op_t OP_TT   = 5'd3;
  localparam op_t OP_D72  = 5'd4;
  localparam op_t OP_M1   = 5'd5;
  localparam op_t OP_D42  = 5'd6;
  localparam op_t OP_M2   = 5'd7;
  localparam op_t OP_D20  = 5'd8;
  localparam op_t OP_M3   = 5'd9;
  localparam op_t OP_D6   = 5'd10;
  localparam op_t OP_MF   = 5'd11;
  localparam op_t OP_SIN  = 5'd12;
  localparam op_t OP_XY   = 5'd13;
  localparam op_t OP_X    = 5'd14;
  localparam op_t OP_Y    = 5'd15;
  localparam op_t OP_ZM   = 5'd16;
  localparam op_t OP_ZV   = 5'd17;
  localparam op_t OP_ZD   = 5'd18;
  localparam op_t OP_OUT  = 5'd19;

  localparam logic [3:0] SIN_LAST = 4'd11;
  localparam logic [2:0] PNT_LAST = 3'd5;

  typedef struct packed {
    op_t               op;
    logic              pass;
    logic              cap_time;
    logic              az_lo;
    logic              az_hi;
    logic              rng_lo;
    logic              rng_hi;
    logic              pt_start;
    logic [LCNT_W-1:0] laser;
    logic [SEQ_W-1:0]  seq;
    logic [BLK_W-1:0]  blk;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  function automatic op_t sin_op(input logic [3:0] step);
    op_t op;
    unique case (step)
      4'd0:    op = OP_ANG;
      4'd1:    op = OP_T;
      4'd2:    op = OP_TT;
      4'd3:    op = OP_D72;
      4'd4:    op = OP_M1;
      4'd5:    op = OP_D42;
      4'd6:    op = OP_M2;
      4'd7:    op = OP_D20;
      4'd8:    op = OP_M3;
      4'd9:    op = OP_D6;
      4'd10:   op = OP_MF;
      4'd11:   op = OP_SIN;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic op_t pnt_op(input logic [2:0] step);
    op_t op;
    unique case (step)
      3'd0:    op = OP_XY;
      3'd1:    op = OP_X;
      3'd2:    op = OP_Y;
      3'd3:    op = OP_ZM;
      3'd4:    op = OP_ZV;
      3'd5:    op = OP_ZD;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  // Vertical sine of each laser, Q1.15.
  function automatic logic signed [15:0] vert_sin(input logic [3:0] l);
    logic signed [15:0] v;
    case (l)
      4'd0:  v = -16'sd8481;
      4'd1:  v = 16'sd572;
      4'd2:  v = -16'sd7371;
      4'd3:  v = 16'sd1715;
      4'd4:  v = -16'sd6252;
      4'd5:  v = 16'sd2856;
      4'd6:  v = -16'sd5126;
      4'd7:  v = 16'sd3993;
      4'd8:  v = -16'sd3993;
      4'd9:  v = 16'sd5126;
      4'd10: v = -16'sd2856;
      4'd11: v = 16'sd6252;
      4'd12: v = -16'sd1715;
      4'd13: v = 16'sd7371;
      4'd14: v = -16'sd572;
      default: v = 16'sd8481;
    endcase
    return v;
  endfunction

  // Vertical cosine of each laser, Q1.15.
  function automatic logic signed [15:0] vert_cos(input logic [3:0] l);
    logic signed [15:0] v;
    case (l)
      4'd0:  v = 16'sd31651;
      4'd1:  v = 16'sd32763;
      4'd2:  v = 16'sd31928;
      4'd3:  v = 16'sd32723;
      4'd4:  v = 16'sd32166;
      4'd5:  v = 16'sd32643;
      4'd6:  v = 16'sd32365;
      4'd7:  v = 16'sd32524;
      4'd8:  v = 16'sd32524;
      4'd9:  v = 16'sd32365;
      4'd10: v = 16'sd32643;
      4'd11: v = 16'sd32166;
      4'd12: v = 16'sd32723;
      4'd13: v = 16'sd31928;
      4'd14: v = 16'sd32763;
      default: v = 16'sd31651;
    endcase
    return v;
  endfunction

  // Vertical offset of each laser in tenths of a millimeter.
  function automatic logic signed [15:0] vert_corr(input logic [3:0] l);
    logic signed [15:0] v;
    case (l)
      4'd0:  v = 16'sd112;
      4'd1:  v = -16'sd7;
      4'd2:  v = 16'sd97;
      4'd3:  v = -16'sd22;
      4'd4:  v = 16'sd81;
      4'd5:  v = -16'sd37;
      4'd6:  v = 16'sd66;
      4'd7:  v = -16'sd51;
      4'd8:  v = 16'sd51;
      4'd9:  v = -16'sd66;
      4'd10: v = 16'sd37;
      4'd11: v = -16'sd81;
      4'd12: v = 16'sd22;
      4'd13: v = -16'sd97;
      4'd14: v = 16'sd7;
      default: v = -16'sd112;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/l16p_if.sv -----
// ----------------------------------------------------------------------------
// l16p_if
// Valid/ready channels for packet bytes and decoded points.
// ----------------------------------------------------------------------------
interface l16p_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [29:0] packet_time_ns;
  logic        packet_end;

  modport source (output valid, data_byte, packet_time_ns, packet_end, input ready);
  modport sink   (input valid, data_byte, packet_time_ns, packet_end, output ready);
endinterface

interface l16p_point_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] x_mm;
  logic signed [17:0] y_mm;
  logic signed [18:0] z_mm;
  logic [7:0]         intensity;
  logic [3:0]         laser;
  logic [29:0]        time_offset_ns;

  modport source (output valid, x_mm, y_mm, z_mm, intensity, laser, time_offset_ns,
                  input ready);
  modport sink   (input valid, x_mm, y_mm, z_mm, intensity, laser, time_offset_ns,
                  output ready);
endinterface

// ----- hdl/l16p_ctrl.sv -----
// ----------------------------------------------------------------------------
// l16p_ctrl
// Tracks the byte position in the packet and sequences the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module l16p_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            packet_end_i,
  output logic            in_ready_o,
  input  l16p_pkg::stat_t stat_i,
  output l16p_pkg::cmd_t  cmd_o
);
  import l16p_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SIN  = 2'd1;
  localparam logic [1:0] ST_PNT  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [1:0]        sub_q, sub_d;
  logic [LCNT_W-1:0] laser_q, laser_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [3:0]        step_q, step_d;
  logic              pass_q, pass_d;
  logic              accept;
  logic              active;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign active     = (blk_q < BLK_W'(BLOCKS));

  always_comb begin
    state_d = state_q;
    blk_d   = blk_q;
    off_d   = off_q;
    sub_d   = sub_q;
    laser_d = laser_q;
    seq_d   = seq_q;
    step_d  = step_q;
    pass_d  = pass_q;

    cmd_o          = '0;
    cmd_o.op       = OP_NONE;
    cmd_o.pass     = pass_q;
    cmd_o.laser    = laser_q;
    cmd_o.seq      = seq_q;
    cmd_o.blk      = blk_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.cap_time = (blk_q == '0) && (off_q == '0);
          if (active) begin
            if (off_q == OFF_W'(OFF_AZ_LO)) begin
              cmd_o.az_lo = 1'b1;
            end else if (off_q == OFF_W'(OFF_AZ_HI)) begin
              cmd_o.az_hi = 1'b1;
              state_d     = ST_SIN;
              step_d      = '0;
              pass_d      = 1'b0;
            end else if (off_q >= OFF_W'(HEADER_BYTES)) begin
              if (sub_q == SUB_LO) begin
                cmd_o.rng_lo = 1'b1;
              end else if (sub_q == SUB_HI) begin
                cmd_o.rng_hi = 1'b1;
              end else begin
                cmd_o.pt_start = 1'b1;
                state_d        = ST_PNT;
                step_d         = '0;
              end
            end
          end

          if (packet_end_i) begin
            blk_d   = '0;
            off_d   = '0;
            sub_d   = SUB_LO;
            laser_d = '0;
            seq_d   = '0;
          end else if (active) begin
            if (off_q == OFF_W'(BLOCK_BYTES - 1)) begin
              off_d   = '0;
              blk_d   = blk_q + 1'b1;
              sub_d   = SUB_LO;
              laser_d = '0;
              seq_d   = '0;
            end else begin
              off_d = off_q + 1'b1;
              if (off_q >= OFF_W'(HEADER_BYTES)) begin
                if (sub_q == SUB_INT) begin
                  sub_d = SUB_LO;
                  if (laser_q == LCNT_W'(LASERS - 1)) begin
                    laser_d = '0;
                    seq_d   = seq_q + 1'b1;
                  end else begin
                    laser_d = laser_q + 1'b1;
                  end
                end else begin
                  sub_d = sub_q + 1'b1;
                end
              end
            end
          end
        end
      end
      ST_SIN: begin
        cmd_o.op = sin_op(step_q);
        if (step_q == SIN_LAST) begin
          step_d = '0;
          if (pass_q) begin
            state_d = ST_IDLE;
          end else begin
            pass_d = 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_PNT: begin
        cmd_o.op = pnt_op(step_q[2:0]);
        if (step_q[2:0] == PNT_LAST) begin
          state_d = ST_OUT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      blk_q   <= '0;
      off_q   <= '0;
      sub_q   <= SUB_LO;
      laser_q <= '0;
      seq_q   <= '0;
      step_q  <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      blk_q   <= blk_d;
      off_q   <= off_d;
      sub_q   <= sub_d;
      laser_q <= laser_d;
      seq_q   <= seq_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

  `L16P_ASSERT(a_pt_starts_point, accept && cmd_o.pt_start |=> state_q == ST_PNT,
               "intensity byte did not start a point")
  `L16P_ASSERT(a_sin_step_range, state_q == ST_SIN |-> step_q <= SIN_LAST,
               "sine step counter out of range")
  `L16P_ASSERT(a_out_holds, state_q == ST_OUT && stat_i.out_busy |=> state_q == ST_OUT,
               "point left the output stage while the output was busy")

endmodule

// ----- hdl/l16p_datapath.sv -----
// ----------------------------------------------------------------------------
// l16p_datapath
// Field capture, shared multiplier for sine and point math, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module l16p_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  l16p_pkg::cmd_t     cmd_i,
  output l16p_pkg::stat_t    stat_o,
  input  logic [7:0]         data_byte_i,
  input  logic [29:0]        packet_time_ns_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] x_mm_o,
  output logic signed [18:0] z_mm_o,
  output logic signed [17:0] y_mm_o,
  output logic [7:0]         intensity_o,
  output logic [3:0]         laser_o,
  output logic [29:0]        time_offset_ns_o
);
  import l16p_pkg::*;

  logic [15:0]        az_q;
  logic [7:0]         rlo_q;
  logic [15:0]        rval_q;
  logic [29:0]        ptime_q;
  logic [16:0]        ang_q;
  logic signed [69:0] prod_q;
  logic [30:0]        t_q;
  logic [31:0]        t2_q;
  logic [30:0]        p_q;
  logic               neg_q;
  logic signed [16:0] sa_q, ca_q;
  logic [LCNT_W-1:0]  laser_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [BLK_W-1:0]   blk_q;
  logic [7:0]         inten_q;
  logic signed [34:0] xy_q;
  logic signed [17:0] x_q, y_q;
  logic [18:0]        zv_q;
  logic               zneg_q;
  logic [29:0]        tsum_q;
  logic               out_valid_q;

  logic signed [35:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [69:0] prod_d;
  logic [16:0]        az_w, ang_base, ang_sum, ang_next;
  logic [13:0]        rq;
  logic               rneg;
  logic [30:0]        quo, p_new;
  logic [31:0]        s_full;
  logic [16:0]        s_mag;
  logic signed [16:0] s_val;
  logic [3:0]         lidx;
  logic signed [15:0] vsin, vcos, vcorr;
  logic [16:0]        r17;
  logic signed [34:0] zr;
  logic signed [40:0] zn;
  logic [40:0]        zmag, zsum;
  logic [18:0]        zq;
  logic [31:0]        tsum_full;

  // Round to nearest, ties away from zero, after a 30-bit right shift.
  function automatic logic [17:0] round30(input logic signed [69:0] n);
    logic [69:0] m;
    logic [69:0] s;
    m = n[69] ? 70'(-n) : 70'(n);
    s = (m + (70'd1 << 29)) >> 30;
    return n[69] ? 18'(-s[17:0]) : s[17:0];
  endfunction

  assign lidx  = 4'(laser_q);
  assign vsin  = vert_sin(lidx);
  assign vcos  = vert_cos(lidx);
  assign vcorr = vert_corr(lidx);
  assign r17   = {rval_q, 1'b0};

  // Azimuth plus a quarter turn, wrapped into one turn; the second pass adds a further quarter turn.
  always_comb begin
    az_w     = ({1'b0, az_q} >= AZ_FULL) ? ({1'b0, az_q} - AZ_FULL) : {1'b0, az_q};
    ang_base = cmd_i.pass ? ang_q : az_w;
    ang_sum  = ang_base + AZ_QUARTER;
    ang_next = (ang_sum >= AZ_FULL) ? (ang_sum - AZ_FULL) : ang_sum;
  end

  // Fold the angle onto the first quadrant.
  always_comb begin
    if (ang_q < AZ_QUARTER) begin
      rq   = 14'(ang_q);
      rneg = 1'b0;
    end else if (ang_q < AZ_HALF) begin
      rq   = 14'(AZ_HALF - ang_q);
      rneg = 1'b0;
    end else if (ang_q < AZ_3QUART) begin
      rq   = 14'(ang_q - AZ_HALF);
      rneg = 1'b1;
    end else begin
      rq   = 14'(AZ_FULL - ang_q);
      rneg = 1'b1;
    end
  end

  // Each Horner step takes the quotient out of the reciprocal product.
  always_comb begin
    case (cmd_i.op)
      OP_M1:   quo = prod_q[39 +: 31];
      OP_M2:   quo = prod_q[38 +: 31];
      OP_M3:   quo = prod_q[37 +: 31];
      OP_MF:   quo = prod_q[35 +: 31];
      default: quo = '0;
    endcase
    p_new = Q30_ONE - quo;
  end

  always_comb begin
    s_full = {1'b0, prod_q[60:30]} + 32'd16384;
    s_mag  = s_full[31:15];
    s_val  = neg_q ? -signed'(s_mag) : signed'(s_mag);
  end

  always_comb begin
    zr   = signed'(prod_q[34:0]);
    zn   = (41'(zr) <<< 3) + (41'(zr) <<< 1) + (41'(vcorr) <<< 15);
    zmag = zn[40] ? 41'(-zn) : 41'(zn);
    zsum = zmag + 41'd163840;
    zq   = prod_q[22 +: 19];
  end

  assign tsum_full = {2'b00, ptime_q} + 32'(blk_q) * BLOCK_NS
                   + 32'(seq_q) * SEQUENCE_NS + 32'(laser_q) * CHANNEL_NS;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op) inside
      OP_T: begin
        mul_a = 36'(rq);
        mul_b = SIN_K;
      end
      OP_TT: begin
        mul_a = 36'(prod_q[30:0]);
        mul_b = 34'(prod_q[30:0]);
      end
      OP_D72: begin
        mul_a = 36'(prod_q[61:30]);
        mul_b = M72[33:0];
      end
      OP_D42: begin
        mul_a = 36'(prod_q[61:30]);
        mul_b = M42[33:0];
      end
      OP_D20: begin
        mul_a = 36'(prod_q[61:30]);
        mul_b = M20[33:0];
      end
      OP_D6: begin
        mul_a = 36'(prod_q[61:30]);
        mul_b = M6[33:0];
      end
      OP_M1, OP_M2, OP_M3: begin
        mul_a = 36'(t2_q);
        mul_b = 34'(p_new);
      end
      OP_MF: begin
        mul_a = 36'(t_q);
        mul_b = 34'(p_new);
      end
      OP_XY: begin
        mul_a = 36'(r17);
        mul_b = 34'(vcos);
      end
      OP_X: begin
        mul_a = 36'(signed'(prod_q[34:0]));
        mul_b = 34'(sa_q);
      end
      OP_Y: begin
        mul_a = 36'(xy_q);
        mul_b = 34'(ca_q);
      end
      OP_ZM: begin
        mul_a = 36'(r17);
        mul_b = 34'(vsin);
      end
      OP_ZD: begin
        mul_a = 36'(zv_q);
        mul_b = M5[33:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_q    <= '0;
      rlo_q   <= '0;
      rval_q  <= '0;
      ptime_q <= '0;
      sa_q    <= '0;
      ca_q    <= '0;
    end else begin
      if (cmd_i.cap_time) ptime_q <= packet_time_ns_i;
      if (cmd_i.az_lo) az_q[7:0] <= data_byte_i;
      if (cmd_i.az_hi) az_q[15:8] <= data_byte_i;
      if (cmd_i.rng_lo) rlo_q <= data_byte_i;
      if (cmd_i.rng_hi) rval_q <= {data_byte_i, rlo_q};
      if (cmd_i.op == OP_SIN) begin
        if (cmd_i.pass) ca_q <= s_val;
        else sa_q <= s_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_start) begin
      laser_q <= cmd_i.laser;
      seq_q   <= cmd_i.seq;
      blk_q   <= cmd_i.blk;
      inten_q <= data_byte_i;
    end
    if (cmd_i.op != OP_NONE && cmd_i.op != OP_ANG && cmd_i.op != OP_SIN &&
        cmd_i.op != OP_ZV && cmd_i.op != OP_OUT) begin
      prod_q <= prod_d;
    end
    case (cmd_i.op) inside
      OP_ANG: ang_q <= ang_next;
      OP_T:   neg_q <= rneg;
      OP_TT:  t_q <= prod_q[30:0];
      OP_D72: t2_q <= prod_q[61:30];
      OP_M1, OP_M2, OP_M3, OP_MF: p_q <= p_new;
      OP_XY:  tsum_q <= tsum_full[29:0];
      OP_X:   xy_q <= signed'(prod_q[34:0]);
      OP_Y:   x_q <= round30(prod_q);
      OP_ZM:  y_q <= round30(prod_q);
      OP_ZV: begin
        zneg_q <= zn[40];
        zv_q   <= zsum[34:16];
      end
      OP_OUT: begin
        x_mm_o           <= x_q;
        y_mm_o           <= y_q;
        z_mm_o           <= zneg_q ? -signed'(zq) : signed'(zq);
        intensity_o      <= inten_q;
        laser_o          <= lidx;
        time_offset_ns_o <= tsum_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  `L16P_NEVER(a_no_overwrite, cmd_i.op == OP_OUT && out_valid_q && !out_ready_i,
              "point loaded over an untaken point")
  `L16P_ASSERT(a_sine_bound,
               cmd_i.op == OP_SIN && !cmd_i.pass |=> sa_q <= 32768 && sa_q >= -32768,
               "azimuth sine out of Q1.15 range")
  `L16P_ASSERT(a_horner_bound, $past(cmd_i.op == OP_M1) |-> p_q <= Q30_ONE,
               "Horner term above one")

endmodule

// ----- hdl/lidar16_packet_to_points_top.sv -----
// Point path: after an intensity byte is accepted, the shared multiplier computes x, y and z, and
// the point is then loaded into the output registers once the output is free. Range bytes do not
// hold the input; an intensity byte holds it until its point is loaded. The azimuth high byte holds
// it for two 12-step sine evaluations on the same multiplier.
// Reset: asynchronous, active low; clears the byte position, the sequencer and the output valid.
// ----------------------------------------------------------------------------
// lidar16_packet_to_points_top
// Decodes lidar packet bytes into Cartesian points with time and intensity.
// ----------------------------------------------------------------------------
module lidar16_packet_to_points_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  l16p_byte_if.sink     byte_i,
  l16p_point_if.source  point_o
);
  import l16p_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  l16p_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_i.valid),
    .packet_end_i (byte_i.packet_end),
    .in_ready_o   (byte_i.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  l16p_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .data_byte_i      (byte_i.data_byte),
    .packet_time_ns_i (byte_i.packet_time_ns),
    .out_valid_o      (point_o.valid),
    .out_ready_i      (point_o.ready),
    .x_mm_o           (point_o.x_mm),
    .z_mm_o           (point_o.z_mm),
    .y_mm_o           (point_o.y_mm),
    .intensity_o      (point_o.intensity),
    .laser_o          (point_o.laser),
    .time_offset_ns_o (point_o.time_offset_ns)
  );

endmodule

// ----- bench/tb_channels.sv -----
// ----------------------------------------------------------------------------
// tb_channels
// Test bench view of the packet byte and point channels.
// The channel interfaces themselves come from the design's interface file.
// ----------------------------------------------------------------------------
package tb_channels_pkg;
  // Default idle draw range, shared by the byte sender and the point receiver.
  localparam int unsigned IDLE_MAX = 9;
endpackage

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar packet to point decoder.
// Packet bytes are sent, some with random gaps, every decoded point is predicted in
// fixed point and compared field by field against the block's output.
// ----------------------------------------------------------------------------
module tb_top;
  import l16p_pkg::*;
  import tb_channels_pkg::*;

  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [18:0] z;
    logic [7:0]         inten;
    logic [3:0]         laser;
    logic [29:0]        tns;
  } point_t;

  class point_board;
    int unsigned pos;
    logic [15:0] azim;
    logic [7:0]  rlo;
    logic [15:0] rng;
    logic [29:0] ptime;
    point_t      pending[$];
    int unsigned errors;
    int unsigned seen;

    function automatic longint qsin(longint unsigned r);
      longint unsigned t, t2, p;
      t  = r * 187403;
      t2 = (t * t) >> 30;
      p  = (64'd1 << 30) - t2 / 72;
      p  = (64'd1 << 30) - ((t2 * p) >> 30) / 42;
      p  = (64'd1 << 30) - ((t2 * p) >> 30) / 20;
      p  = (64'd1 << 30) - ((t2 * p) >> 30) / 6;
      return longint'((((t * p) >> 30) + 16384) >> 15);
    endfunction

    function automatic longint sin_cd(int unsigned a);
      int unsigned q, r;
      q = (a % 36000) / 9000;
      r = (a % 36000) % 9000;
      case (q)
        0: return qsin(r);
        1: return qsin(9000 - r);
        2: return -qsin(r);
        default: return -qsin(9000 - r);
      endcase
    endfunction

    function automatic longint rnd(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function void note_byte(logic [7:0] b, logic [29:0] tin, logic last);
      int unsigned blk, off, rec, sub, lz, sq, a;
      longint r, xy, sa, ca;
      point_t p;
      if (pos == 0) ptime = tin;
      if (pos < BLOCKS * BLOCK_BYTES) begin
        blk = pos / BLOCK_BYTES;
        off = pos % BLOCK_BYTES;
        if (off == OFF_AZ_LO) begin
          azim[7:0] = b;
        end else if (off == OFF_AZ_HI) begin
          azim[15:8] = b;
        end else if (off >= HEADER_BYTES) begin
          rec = (off - HEADER_BYTES) / RECORD_BYTES;
          sub = (off - HEADER_BYTES) % RECORD_BYTES;
          if (sub == SUB_LO) begin
            rlo = b;
          end else if (sub == SUB_HI) begin
            rng = {b, rlo};
          end else begin
            lz = rec % LASERS;
            sq = rec / LASERS;
            r  = 2 * longint'(rng);
            a  = (azim % 36000 + 9000) % 36000;
            sa = sin_cd(a);
            ca = sin_cd((a + 9000) % 36000);
            xy = r * longint'(vert_cos(lz[3:0]));
            p.x = 18'(rnd(xy * sa, 64'd1 << 30));
            p.y = 18'(rnd(xy * ca, 64'd1 << 30));
            p.z = 19'(rnd(r * longint'(vert_sin(lz[3:0])) * 10
                          + longint'(vert_corr(lz[3:0])) * 32768, 327680));
            p.inten = b;
            p.laser = lz[3:0];
            p.tns = 30'(ptime + blk * BLOCK_NS + sq * SEQUENCE_NS + lz * CHANNEL_NS);
            pending.insert(pending.size(), p);
          end
        end
      end
      if (last) pos = 0;
      else if (pos < BLOCKS * BLOCK_BYTES) pos++;
    endfunction

    function void check_point(point_t g);
      point_t e;
      seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual x=%0d y=%0d z=%0d", $time,
                 g.x, g.y, g.z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (g.x !== e.x || g.y !== e.y || g.z !== e.z || g.inten !== e.inten ||
          g.laser !== e.laser || g.tns !== e.tns) begin
        $display("%0t: point mismatch expected x=%0d y=%0d z=%0d i=%0d l=%0d t=%0d", $time,
                 e.x, e.y, e.z, e.inten, e.laser, e.tns);
        $display("%0t:                actual   x=%0d y=%0d z=%0d i=%0d l=%0d t=%0d", $time,
                 g.x, g.y, g.z, g.inten, g.laser, g.tns);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic clk_i;
  logic rst_ni;
  l16p_byte_if  byte_if();
  l16p_point_if point_if();
  point_board   board;
  int unsigned  cycles;
  bit           hold_long;
  bit           send_done;
  int unsigned  bytes_sent;

  lidar16_packet_to_points_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if.sink),
    .point_o (point_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sends one packet byte and records it once the transaction completes.
  task automatic send_byte(logic [7:0] b, logic [29:0] tin, logic last, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, IDLE_MAX) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid          <= 1'b1;
    byte_if.data_byte      <= b;
    byte_if.packet_time_ns <= tin;
    byte_if.packet_end     <= last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    board.note_byte(b, tin, last);
    bytes_sent++;
  endtask

  // A packet of nbytes bytes; records carry random ranges or extremes.
  task automatic send_packet(int unsigned nbytes, logic [29:0] tin, bit gaps, int mode);
    logic [7:0] b;
    int unsigned off;
    for (int unsigned i = 0; i < nbytes; i++) begin
      off = i % BLOCK_BYTES;
      b = 8'($urandom_range(0, 255));
      if (mode == 1) b = (off < HEADER_BYTES && off != OFF_AZ_HI) ? b : 8'hFF;
      if (mode == 2) b = 8'h00;
      if (off == OFF_AZ_HI && mode == 0 && $urandom_range(0, 4) != 0)
        b = 8'($urandom_range(0, 140));
      send_byte(b, tin, i == nbytes - 1, gaps);
    end
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // The point receiver with random stalls and one long hold-off.
  initial begin
    int unsigned stall;
    point_t g;
    point_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        point_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall != 0) begin
        point_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      point_if.ready <= 1'b1;
      @(posedge clk_i);
      if (point_if.valid) begin
        g.x = point_if.x_mm;
        g.y = point_if.y_mm;
        g.z = point_if.z_mm;
        g.inten = point_if.intensity;
        g.laser = point_if.laser;
        g.tns = point_if.time_offset_ns;
        board.check_point(g);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] az[4];
    board = new();
    board.pos = 0;
    board.azim = 0;
    board.rlo = 0;
    board.rng = 0;
    board.ptime = 0;
    hold_long = 1'b0;
    bytes_sent = 0;
    byte_if.valid          <= 1'b0;
    byte_if.data_byte      <= 8'h00;
    byte_if.packet_time_ns <= 30'd0;
    byte_if.packet_end     <= 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-ones block with wrapping azimuth and top time, then zeros.
    send_packet(BLOCK_BYTES, 30'h3FFF_FFFF, 1'b0, 1);
    send_packet(BLOCK_BYTES, 30'd0, 1'b1, 2);
    // Azimuths at quadrant boundaries and at the wrap point.
    az = '{8'h00, 8'h23, 8'h8C, 8'hA0};
    foreach (az[k]) begin
      send_byte(8'h00, 30'd1000, 1'b0, 1'b0);
      send_byte(8'h00, 30'd1000, 1'b0, 1'b0);
      send_byte(8'h28, 30'd1000, 1'b0, 1'b0);
      send_byte(az[k], 30'd1000, 1'b0, 1'b0);
      send_byte(8'h34, 30'd1000, 1'b0, 1'b0);
      send_byte(8'h12, 30'd1000, 1'b0, 1'b0);
      send_byte(8'h80, 30'd1000, 1'b1, 1'b0);
    end
    byte_if.valid <= 1'b0;
    @(posedge clk_i);

    // Long hold-off on the point side while bytes keep coming.
    hold_long = 1'b1;
    send_packet(BLOCK_BYTES, 30'($urandom_range(0, 1_000_000_000)), 1'b0, 0);

    // A few short random packets with gaps.
    for (int n = 0; n < 3; n++)
      send_packet($urandom_range(10, 30),
                  30'($urandom_range(0, 30'h3FFF_FFFF)), 1'b1, 0);

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d packet bytes, %0d points checked, including extreme ranges,",
             bytes_sent, board.seen);
    $display("wrapped azimuths and time, quadrant boundaries and a long output stall.");
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
